// File: sv/assert_macros.svh
// Assertion macros shared by the event ring queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ERQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event queue assertion failed");

`endif

// File: sv/erq_pkg.sv
// Package with the types, codes and defaults of the event ring queue.
`timescale 1ns / 1ps

package erq_pkg;

    localparam int ERQ_DEPTH_DEF = 64;
    localparam int KIND_W        = 16;
    localparam int BODY_W        = 64;
    localparam int OCC_W         = 6;
    localparam int DROP_W        = 32;

    // Command codes.
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BODY_W-1:0] body;
    } t_event;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

endpackage

// File: sv/event_ring_queue_with_flush.sv
// Top level of the event ring queue: a row of event cells and its command sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// A command is accepted at a rising clock edge where start is high and busy is low.
// The command is i_func (push, pop or flush by kind) with i_event_kind and
// i_event_body. Every command produces exactly one result item, shown on the o_
// result ports for a single cycle while o_result_valid is high. The receiver cannot
// hold results off, so it must take the item in that cycle.
// The queue holds up to QUEUE_DEPTH - 1 events. Events sit in a row of cells in
// queue order, the oldest in the first cell; a pop shifts the whole row by one.
// For push, pop and unused codes the result appears in the cycle after acceptance,
// and a new command may be accepted in that same cycle.
// A flush of N held events keeps busy high while the row rotates one position per
// cycle, once for each held event; each event leaving the first cell either
// re-enters at the tail or is discarded when its kind matches. The result comes in
// the cycle after the last rotation; an empty flush answers at once.
// Synchronous active-low reset empties the queue and clears the drop counter; busy
// is high while reset is asserted. Cell contents are not cleared, since a cell is
// only read after it has been written.

module event_ring_queue_with_flush
    import erq_pkg::*;
#(
    parameter int QUEUE_DEPTH = ERQ_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  logic [KIND_W-1:0] i_event_kind,
    input  logic [BODY_W-1:0] i_event_body,
    output logic              o_result_valid,
    output logic [1:0]        o_status,
    output logic [KIND_W-1:0] o_popped_kind,
    output logic [BODY_W-1:0] o_popped_body,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic [DROP_W-1:0] o_drop_count
);

    localparam int CW  = $clog2(QUEUE_DEPTH);
    localparam int CAP = QUEUE_DEPTH - 1;
    localparam logic [CW-1:0]     CAP_C    = CW'(CAP);
    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    // Control state.
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_left, n_left;
    logic [KIND_W-1:0]   r_fkind, n_fkind;
    logic [DROP_W-1:0]   r_drop_total, n_drop_total;
    logic                r_valid, n_valid;

    // Result payload.
    logic [1:0]          r_status, n_status;
    logic [KIND_W-1:0]   r_pop_kind, n_pop_kind;
    logic [BODY_W-1:0]   r_pop_body, n_pop_body;

    // Cell row controls.
    logic                w_accept;
    logic                w_shift_all;
    logic                w_load_go;
    logic [CW-1:0]       w_load_pos;
    t_event              w_load_data;
    t_event              w_head;
    t_event              w_cell [CAP];
    logic [CW+OCC_W-1:0] w_occ_wide;

    assign busy     = (r_state != ST_IDLE) || !i_rst_n;
    assign w_accept = start && !busy;
    assign w_head   = w_cell[0];

    // The row of cells. Each cell takes its right neighbor on a shift; the last one
    // has no neighbor and keeps its own value, which is beyond the occupied part anyway.
    generate
        for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
            t_event w_next;
            if (gi == CAP - 1) begin : g_last
                assign w_next = w_cell[gi];
            end else begin : g_mid
                assign w_next = w_cell[gi + 1];
            end
            erq_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (w_shift_all),
                .i_load      (w_load_go && (w_load_pos == CW'(gi))),
                .i_load_data (w_load_data),
                .i_next_data (w_next),
                .o_data      (w_cell[gi])
            );
        end
    endgenerate

    // Command sequencer.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        n_fkind      = r_fkind;
        n_drop_total = r_drop_total;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_pop_kind   = r_pop_kind;
        n_pop_body   = r_pop_body;
        w_shift_all  = 1'b0;
        w_load_go    = 1'b0;
        w_load_pos   = r_count;
        w_load_data  = '{kind: i_event_kind, body: i_event_body};

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_status   = STAT_DONE;
                    n_pop_kind = '0;
                    n_pop_body = '0;
                    case (i_func)
                        FUNC_PUSH: begin
                            n_valid = 1'b1;
                            if (r_count == CAP_C) begin
                                n_status = STAT_DROPPED;
                                if (r_drop_total != DROP_MAX) begin
                                    n_drop_total = r_drop_total + 1'b1;
                                end
                            end else begin
                                w_load_go = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        FUNC_POP: begin
                            n_valid = 1'b1;
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_pop_kind  = w_head.kind;
                                n_pop_body  = w_head.body;
                                w_shift_all = 1'b1;
                                n_count     = r_count - 1'b1;
                            end
                        end
                        FUNC_FLUSH: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = ST_FLUSH;
                                n_left  = r_count;
                                n_fkind = i_event_kind;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                // Rotate by one: the oldest event either goes back in at the tail or is dropped.
                w_shift_all = 1'b1;
                if (w_head.kind != r_fkind) begin
                    w_load_go   = 1'b1;
                    w_load_pos  = r_count - 1'b1;
                    w_load_data = w_head;
                end else begin
                    n_count = r_count - 1'b1;
                end
                n_left = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_left       <= '0;
            r_fkind      <= '0;
            r_drop_total <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_left       <= n_left;
            r_fkind      <= n_fkind;
            r_drop_total <= n_drop_total;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_pop_kind <= n_pop_kind;
        r_pop_body <= n_pop_body;
    end

    // Occupancy and drop count hold their final values whenever a result is shown,
    // so they are read live.
    assign w_occ_wide     = {{OCC_W{1'b0}}, r_count};
    assign o_occupancy    = w_occ_wide[OCC_W-1:0];
    assign o_drop_count   = r_drop_total;
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_popped_kind  = r_pop_kind;
    assign o_popped_body  = r_pop_body;

    `ERQ_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CAP_C)
    `ERQ_ASSERT_NOW(a_flush_left_nonzero, i_clk, i_rst_n, r_state == ST_FLUSH,
                    (r_left != '0) && (r_left <= r_count))
    `ERQ_ASSERT_NEXT(a_short_cmd_result, i_clk, i_rst_n,
                     w_accept && (i_func != FUNC_FLUSH), o_result_valid)
    `ERQ_ASSERT_NEXT(a_flush_never_grows, i_clk, i_rst_n, r_state == ST_FLUSH,
                     r_count <= $past(r_count))

endmodule

// File: sv/erq_cell.sv
// One storage cell of the event queue row: holds one event in queue order.
`timescale 1ns / 1ps

module erq_cell
    import erq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  logic   i_load,
    input  t_event i_load_data,
    input  t_event i_next_data,
    output t_event o_data
);

    t_event r_data;
    t_event n_data;

    // A load wins over the shift, so the tail cell can take new data while the row moves.
    always_comb begin
        if (i_load) begin
            n_data = i_load_data;
        end else if (i_shift) begin
            n_data = i_next_data;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: tb/tb_event_ring_queue_with_flush.sv
// Self-checking testbench for the event ring queue with drop-on-full and flush-by-kind.
`timescale 1ns / 1ps

module tb_event_ring_queue_with_flush;
    import erq_pkg::*;

    localparam int QUEUE_DEPTH  = ERQ_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1050;

    // Command code 3 has no meaning in the package; the block must answer it as a no-op.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [BODY_W-1:0] BODY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One result item as the block reports it.
    typedef struct packed {
        logic [1:0]        status;
        logic [KIND_W-1:0] kind;
        logic [BODY_W-1:0] body;
        logic [OCC_W-1:0]  occ;
        logic [DROP_W-1:0] drops;
    } t_answer;

    // One row of the directed table. Where fixed is set, the answer is typed in here;
    // otherwise the queue model supplies it.
    typedef struct packed {
        logic [1:0]        func;
        logic [KIND_W-1:0] kind;
        logic [BODY_W-1:0] body;
        logic              fixed;
        t_answer           answer;
    } t_row;

    // Command mixes for the random phases.
    typedef enum int {
        MIX_PACK,
        MIX_FILL,
        MIX_DRAIN,
        MIX_MIXED,
        MIX_PURGE
    } t_mix;

    // Directed part: reset state, extreme kinds and bodies, every command, the unused
    // code, pop on empty, flush on empty, a flush that removes interleaved events, a
    // flush that empties the queue and a flush that matches nothing.
    localparam t_row DIRECTED_ROWS [0:23] = '{
        '{FUNC_POP,    16'h0000, 64'h0, 1'b1,
          '{STAT_EMPTY, 16'h0000, 64'h0, 6'd0, 32'd0}},
        '{FUNC_FLUSH,  16'h1234, 64'h0, 1'b1,
          '{STAT_DONE,  16'h0000, 64'h0, 6'd0, 32'd0}},
        '{FUNC_UNUSED, 16'hFFFF, BODY_ONES, 1'b1,
          '{STAT_DONE,  16'h0000, 64'h0, 6'd0, 32'd0}},
        '{FUNC_PUSH,   16'hFFFF, BODY_ONES, 1'b1,
          '{STAT_DONE,  16'h0000, 64'h0, 6'd1, 32'd0}},
        '{FUNC_PUSH,   16'h0000, 64'h0, 1'b1,
          '{STAT_DONE,  16'h0000, 64'h0, 6'd2, 32'd0}},
        '{FUNC_POP,    16'h0000, 64'h0, 1'b1,
          '{STAT_DONE,  16'hFFFF, BODY_ONES, 6'd1, 32'd0}},
        '{FUNC_POP,    16'hFFFF, BODY_ONES, 1'b1,
          '{STAT_DONE,  16'h0000, 64'h0, 6'd0, 32'd0}},
        '{FUNC_POP,    16'h0000, 64'h0, 1'b1,
          '{STAT_EMPTY, 16'h0000, 64'h0, 6'd0, 32'd0}},
        '{FUNC_PUSH,   16'h00A1, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{FUNC_PUSH,   16'h00B2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{FUNC_PUSH,   16'h00A1, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{FUNC_PUSH,   16'h00C3, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{FUNC_PUSH,   16'h00A1, 64'h0000_0000_0000_0001, 1'b0, '0},
        '{FUNC_FLUSH,  16'h00A1, 64'h0, 1'b0, '0},
        '{FUNC_UNUSED, 16'h00C3, 64'h0, 1'b0, '0},
        '{FUNC_POP,    16'h0000, 64'h0, 1'b0, '0},
        '{FUNC_FLUSH,  16'h00C3, 64'h0, 1'b0, '0},
        '{FUNC_POP,    16'h0000, 64'h0, 1'b0, '0},
        '{FUNC_PUSH,   16'h8000, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{FUNC_PUSH,   16'h7FFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{FUNC_FLUSH,  16'h1234, BODY_ONES, 1'b0, '0},
        '{FUNC_FLUSH,  16'h8000, 64'h0, 1'b0, '0},
        '{FUNC_POP,    16'h0000, 64'h0, 1'b0, '0},
        '{FUNC_POP,    16'h0000, 64'h0, 1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_func = FUNC_PUSH;
    logic [KIND_W-1:0] i_event_kind = '0;
    logic [BODY_W-1:0] i_event_body = '0;
    logic              o_result_valid;
    logic [1:0]        o_status;
    logic [KIND_W-1:0] o_popped_kind;
    logic [BODY_W-1:0] o_popped_body;
    logic [OCC_W-1:0]  o_occupancy;
    logic [DROP_W-1:0] o_drop_count;

    // Queue model: the held events oldest first, and the saturating drop counter.
    // The cell row of the block is not modeled; only the order of the held
    // events and their number are visible at the ports.
    t_event            model_events[$];
    logic [DROP_W-1:0] model_drops = '0;

    // Answers predicted for accepted commands, oldest first.
    t_answer awaited_answers[$];
    int      mismatch_count = 0;

    // Idle gaps of the sender are switched off for some phases, so that runs of
    // back-to-back commands occur as well.
    bit      idle_enabled = 1'b1;

    event_ring_queue_with_flush #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_event_kind(i_event_kind),
        .i_event_body(i_event_body),
        .o_result_valid(o_result_valid),
        .o_status(o_status),
        .o_popped_kind(o_popped_kind),
        .o_popped_body(o_popped_body),
        .o_occupancy(o_occupancy),
        .o_drop_count(o_drop_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one command to the queue model and returns the result it must produce.
    // A push to a queue holding QUEUE_DEPTH - 1 events is dropped and counted, a pop
    // of an empty queue reports empty, and a flush keeps the events of other kinds in
    // their order.
    function automatic t_answer apply_command(logic [1:0] func, logic [KIND_W-1:0] kind,
                                              logic [BODY_W-1:0] body);
        t_answer ans;
        t_event  ev;
        t_event  kept[$];
        ans = '0;
        ans.status = STAT_DONE;
        case (func)
            FUNC_PUSH: begin
                if (model_events.size() == QUEUE_DEPTH - 1) begin
                    ans.status = STAT_DROPPED;
                    if (model_drops != '1) begin
                        model_drops = model_drops + 1'b1;
                    end
                end else begin
                    ev.kind = kind;
                    ev.body = body;
                    model_events.push_back(ev);
                end
            end
            FUNC_POP: begin
                if (model_events.size() == 0) begin
                    ans.status = STAT_EMPTY;
                end else begin
                    ev = model_events.pop_front();
                    ans.kind = ev.kind;
                    ans.body = ev.body;
                end
            end
            FUNC_FLUSH: begin
                foreach (model_events[i]) begin
                    if (model_events[i].kind != kind) begin
                        kept.push_back(model_events[i]);
                    end
                end
                model_events = kept;
            end
            default: begin
            end
        endcase
        ans.occ   = OCC_W'(model_events.size());
        ans.drops = model_drops;
        return ans;
    endfunction

    // Sender gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enabled || r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    // Kinds come mostly from a small pool so that flushes find matches; the rest
    // cover the extremes and every bit of the field.
    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return KIND_W'($urandom_range(0, 3));
        end else if (r < 76) begin
            return '1;
        end else begin
            return KIND_W'($urandom);
        end
    endfunction

    function automatic logic [1:0] pick_func(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_PACK:  return FUNC_PUSH;
            MIX_FILL:  return (r < 80) ? FUNC_PUSH : (r < 92) ? FUNC_POP :
                              (r < 98) ? FUNC_FLUSH : FUNC_UNUSED;
            MIX_DRAIN: return (r < 15) ? FUNC_PUSH : (r < 90) ? FUNC_POP :
                              (r < 97) ? FUNC_FLUSH : FUNC_UNUSED;
            MIX_PURGE: return (r < 50) ? FUNC_PUSH : (r < 70) ? FUNC_POP : FUNC_FLUSH;
            default:   return (r < 48) ? FUNC_PUSH : (r < 88) ? FUNC_POP :
                              (r < 96) ? FUNC_FLUSH : FUNC_UNUSED;
        endcase
    endfunction

    // Issues one item. Called at a falling edge and returns at a falling edge. During
    // an idle gap start is low and the command fields carry noise, which the block
    // must ignore. The item stays on the ports until an edge sees busy low; the model
    // is stepped at that edge, and a typed answer replaces the predicted one.
    task automatic send_item(logic [1:0] func, logic [KIND_W-1:0] kind,
                             logic [BODY_W-1:0] body, logic fixed, t_answer answer);
        int      gap;
        t_answer predicted;
        gap = pick_gap();
        if (gap > 0) begin
            start        <= 1'b0;
            i_func       <= 2'($urandom);
            i_event_kind <= KIND_W'($urandom);
            i_event_body <= {$urandom, $urandom};
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= func;
        i_event_kind <= kind;
        i_event_body <= body;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_command(func, kind, body);
        awaited_answers.push_back(fixed ? answer : predicted);
        @(negedge i_clk);
    endtask

    // Holds the sender off until the block has answered every accepted item. The
    // first wait guarantees that start is not lowered and raised in one time step.
    task automatic wait_for_answers();
        start <= 1'b0;
        @(negedge i_clk);
        while (awaited_answers.size() != 0) @(negedge i_clk);
    endtask

    // Result checker. Every result is compared field by field with the oldest
    // awaited answer; a result with none awaited is a failure of its own.
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_result_valid) begin
            if (awaited_answers.size() == 0) begin
                $error("result item with no command outstanding: status %0d occupancy %0d",
                       o_status, o_occupancy);
                mismatch_count++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_popped_kind !== want.kind) begin
                    $error("popped_kind: expected %h, got %h", want.kind, o_popped_kind);
                    mismatch_count++;
                end
                if (o_popped_body !== want.body) begin
                    $error("popped_body: expected %h, got %h", want.body, o_popped_body);
                    mismatch_count++;
                end
                if (o_occupancy !== want.occ) begin
                    $error("occupancy: expected %0d, got %0d", want.occ, o_occupancy);
                    mismatch_count++;
                end
                if (o_drop_count !== want.drops) begin
                    $error("drop_count: expected %0d, got %0d", want.drops, o_drop_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases of differing command
    // mix. The first random phase only pushes, so the queue fills and drops follow.
    initial begin : stimulus
        t_mix mix;
        int   phase_len;
        int   sent;
        bit   first_phase;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            send_item(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].body,
                      DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].answer);
        end
        wait_for_answers();

        sent        = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            mix          = first_phase ? MIX_PACK : t_mix'($urandom_range(0, 4));
            phase_len    = first_phase ? 75 : $urandom_range(10, 120);
            idle_enabled = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                send_item(pick_func(mix), pick_kind(), {$urandom, $urandom}, 1'b0, '0);
                sent++;
            end
            // Now and then the sender waits for the block to catch up completely.
            if ($urandom_range(0, 3) == 0) begin
                wait_for_answers();
            end
            first_phase = 1'b0;
        end

        // Drain, then allow the length of a full flush for any stray result.
        start <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (2 * QUEUE_DEPTH) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0 && awaited_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run of long gaps and full flushes.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/erq_pkg.sv
sv/erq_cell.sv
sv/event_ring_queue_with_flush.sv
tb/tb_event_ring_queue_with_flush.sv
